### hdl/hms_pkg.sv
// shared types and constants for the height field max slope block
// no dependencies; every other file refers to this package by scoped names
`default_nettype none

package hms_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int ROW_LIMIT    = 4096;
	localparam int ROW_W        = $clog2(ROW_LIMIT);
	localparam int HEIGHT_W     = 16;
	localparam int SLOPE_W      = 16;
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam int PADDR_W      = 3;

	// request codes
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_FLUSH  = 1'b1;

	// register indexes
	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(1024);
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(1024);

	// one unit of work handed from the front to the back
	typedef struct packed {
		logic                       emit;
		logic                       write_en;
		logic                       use_below;
		logic                       use_upper;
		logic                       use_left;
		logic                       use_right;
		logic                       last;
		logic [COL_W-1:0]           col;
		logic [ROW_W-1:0]           row;
		logic signed [HEIGHT_W-1:0] height;
	} job_t;

endpackage

`default_nettype wire

### hdl/heightfield_max_slope_unit.sv
// four-neighbour max downhill slope of a raster height grid, one result per finished cell
// in the back an item with no result only reads and gathers; one with a result also waits
// on the slope unit (34-step divider, 17-step square root) and on the output register
// front accepts while the queue has room
// reset: position counters clear, grid_width and grid_height read 1024, row stores not cleared
// depends on hms_pkg, hms_front, hms_queue, hms_back
`default_nettype none

module heightfield_max_slope_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [hms_pkg::PADDR_W-1:0]          paddr,
	input  wire logic [31:0]                          pwdata,
	output logic [31:0]                               prdata,
	output logic                                      pready,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic                                 req_type,
	input  wire logic signed [hms_pkg::HEIGHT_W-1:0]  height,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [hms_pkg::SLOPE_W-1:0]               slope,
	output logic [hms_pkg::COL_W-1:0]                 cell_col,
	output logic [hms_pkg::ROW_W-1:0]                 cell_row,
	output logic                                      frame_last
);

	logic [hms_pkg::WIDTH_REG_W-1:0]  grid_width_q;
	logic [hms_pkg::HEIGHT_REG_W-1:0] grid_height_q;
	logic [hms_pkg::WIDTH_REG_W-1:0]  eff_width;
	logic [hms_pkg::HEIGHT_REG_W-1:0] eff_height;
	logic                             cfg_wr;
	logic                             reg_sel;

	logic          push;
	hms_pkg::job_t push_job;
	logic          full;
	logic          pop;
	hms_pkg::job_t head;
	logic          not_empty;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign cfg_wr  = psel && penable && pwrite;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= hms_pkg::WIDTH_RESET;
			grid_height_q <= hms_pkg::HEIGHT_RESET;
		end else if (cfg_wr) begin
			case (reg_sel)
				hms_pkg::REG_GRID_WIDTH:  grid_width_q  <= pwdata[hms_pkg::WIDTH_REG_W-1:0];
				hms_pkg::REG_GRID_HEIGHT: grid_height_q <= pwdata[hms_pkg::HEIGHT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			hms_pkg::REG_GRID_WIDTH:  prdata = 32'(grid_width_q);
			hms_pkg::REG_GRID_HEIGHT: prdata = 32'(grid_height_q);
			default:                  prdata = '0;
		endcase
	end

	// clamp register values to the usable range
	always_comb begin
		if (grid_width_q == '0) begin
			eff_width = hms_pkg::WIDTH_REG_W'(1);
		end else if (grid_width_q > hms_pkg::WIDTH_REG_W'(hms_pkg::MAX_WIDTH)) begin
			eff_width = hms_pkg::WIDTH_REG_W'(hms_pkg::MAX_WIDTH);
		end else begin
			eff_width = grid_width_q;
		end
		if (grid_height_q == '0) begin
			eff_height = hms_pkg::HEIGHT_REG_W'(1);
		end else if (grid_height_q > hms_pkg::HEIGHT_REG_W'(hms_pkg::ROW_LIMIT)) begin
			eff_height = hms_pkg::HEIGHT_REG_W'(hms_pkg::ROW_LIMIT);
		end else begin
			eff_height = grid_height_q;
		end
	end

	hms_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.eff_width  (eff_width),
		.eff_height (eff_height),
		.restart    (cfg_wr),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.height     (height),
		.push       (push),
		.job        (push_job),
		.full       (full)
	);

	hms_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_job),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty)
	);

	hms_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (not_empty),
		.q_head     (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.slope      (slope),
		.cell_col   (cell_col),
		.cell_row   (cell_row),
		.frame_last (frame_last)
	);

endmodule

`default_nettype wire

### hdl/hms_front.sv
// front: accepts beats, tracks raster position and flush count, builds jobs
// depends on hms_pkg
`default_nettype none

module hms_front (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic [hms_pkg::WIDTH_REG_W-1:0]       eff_width,
	input  wire logic [hms_pkg::HEIGHT_REG_W-1:0]      eff_height,
	input  wire logic                                  restart,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic                                  req_type,
	input  wire logic signed [hms_pkg::HEIGHT_W-1:0]   height,
	output logic                                       push,
	output hms_pkg::job_t                              job,
	input  wire logic                                  full
);

	logic [hms_pkg::COL_W-1:0]       column_q;
	logic [hms_pkg::ROW_W-1:0]       row_q;
	logic [hms_pkg::WIDTH_REG_W-1:0] flush_q;

	logic                            accept;
	logic [hms_pkg::WIDTH_REG_W-1:0] w_m1;
	logic [hms_pkg::COL_W-1:0]       col_s;
	logic [hms_pkg::WIDTH_REG_W-1:0] col_inc;
	logic                            at_end;
	logic [hms_pkg::HEIGHT_REG_W-1:0] row_inc;
	logic                            row_end;
	logic                            fl_ok;
	logic [hms_pkg::WIDTH_REG_W-1:0] fl_diff;
	logic [hms_pkg::COL_W-1:0]       col_f;
	logic [hms_pkg::HEIGHT_REG_W-1:0] h_m1;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	// sample position, clamped to the last column
	assign w_m1    = eff_width - 1'b1;
	assign col_s   = ({1'b0, column_q} >= w_m1) ? w_m1[hms_pkg::COL_W-1:0] : column_q;
	assign col_inc = {1'b0, col_s} + 1'b1;
	assign at_end  = col_inc >= eff_width;
	assign row_inc = {1'b0, row_q} + 1'b1;
	assign row_end = row_inc >= eff_height;

	// flush position
	assign fl_ok   = (flush_q != '0) && (flush_q <= eff_width);
	assign fl_diff = eff_width - flush_q;
	assign col_f   = fl_diff[hms_pkg::COL_W-1:0];
	assign h_m1    = eff_height - 1'b1;

	// job build
	always_comb begin
		job = '0;
		if (req_type == hms_pkg::REQ_FLUSH) begin
			job.emit      = 1'b1;
			job.write_en  = 1'b0;
			job.use_below = 1'b0;
			job.use_upper = eff_height[hms_pkg::HEIGHT_REG_W-1:1] != '0;
			job.use_left  = col_f != '0;
			job.use_right = ({1'b0, col_f} + 1'b1) < eff_width;
			job.last      = flush_q == hms_pkg::WIDTH_REG_W'(1);
			job.col       = col_f;
			job.row       = h_m1[hms_pkg::ROW_W-1:0];
			job.height    = height;
		end else begin
			job.emit      = row_q != '0;
			job.write_en  = 1'b1;
			job.use_below = 1'b1;
			job.use_upper = row_q[hms_pkg::ROW_W-1:1] != '0;
			job.use_left  = col_s != '0;
			job.use_right = !at_end;
			job.last      = 1'b0;
			job.col       = col_s;
			job.row       = row_q - 1'b1;
			job.height    = height;
		end
	end

	assign push = accept && ((req_type == hms_pkg::REQ_SAMPLE) || fl_ok);

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
			flush_q  <= '0;
		end else if (restart) begin
			column_q <= '0;
			row_q    <= '0;
			flush_q  <= '0;
		end else if (accept) begin
			if (req_type == hms_pkg::REQ_FLUSH) begin
				flush_q <= fl_ok ? flush_q - 1'b1 : '0;
			end else begin
				flush_q <= '0;
				if (at_end) begin
					column_q <= '0;
					if (row_end) begin
						row_q   <= '0;
						flush_q <= eff_width;
					end else begin
						row_q <= row_inc[hms_pkg::ROW_W-1:0];
					end
				end else begin
					column_q <= col_inc[hms_pkg::COL_W-1:0];
				end
			end
		end
	end

endmodule

`default_nettype wire

### hdl/hms_queue.sv
// two-entry job queue between front and back
// depends on hms_pkg
`default_nettype none

module hms_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire hms_pkg::job_t push_data,
	output logic               full,
	input  wire logic          pop,
	output hms_pkg::job_t      head,
	output logic               not_empty
);

	hms_pkg::job_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign full      = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign head      = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

`default_nettype wire

### hdl/hms_slope.sv
// slope unit: d/sqrt(1+d*d) as Q0.16 for drop d in Q8.8, via restoring divide and bitwise square root
// depends on hms_pkg
`default_nettype none

module hms_slope (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [hms_pkg::SLOPE_W-1:0] drop,
	output logic                             done,
	output logic [hms_pkg::SLOPE_W-1:0]      value
);

	localparam int DIV_STEPS = 34;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MUL  = 5'b00010,
		S_PREP = 5'b00100,
		S_DIV  = 5'b01000,
		S_SQRT = 5'b10000
	} state_t;

	state_t       state_q;
	logic [15:0]  d_q;
	logic [31:0]  d2_q;
	logic [32:0]  den_q;
	logic [32:0]  rem_q;
	logic [33:0]  quo_q;
	logic [5:0]   cnt_q;
	logic [33:0]  x_q;
	logic [33:0]  res_q;
	logic [33:0]  bit_q;
	logic [15:0]  value_q;
	logic         done_q;

	logic [33:0]  t;
	logic         div_ge;
	logic [33:0]  t_sub;
	logic [34:0]  sum;
	logic         sq_ge;
	logic [33:0]  res_nxt;
	logic [18:0]  rnd;

	// divide step
	assign t      = {rem_q, 1'b0};
	assign div_ge = t >= {1'b0, den_q};
	assign t_sub  = t - {1'b0, den_q};

	// square root step
	assign sum     = {1'b0, res_q} + {1'b0, bit_q};
	assign sq_ge   = {1'b0, x_q} >= sum;
	assign res_nxt = sq_ge ? ({1'b0, res_q[33:1]} + bit_q) : {1'b0, res_q[33:1]};
	assign rnd     = {1'b0, res_nxt[17:0]} + 19'd1;

	assign done  = done_q;
	assign value = value_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: if (start) state_q <= S_MUL;
				S_MUL:  state_q <= S_PREP;
				S_PREP: state_q <= S_DIV;
				S_DIV:  if (cnt_q == '0) state_q <= S_SQRT;
				S_SQRT: begin
					if (bit_q[0]) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: d_q <= drop;
			S_MUL:  d2_q <= 32'(d_q * d_q);
			S_PREP: begin
				den_q <= {1'b0, d2_q} + 33'd65536;
				rem_q <= {1'b0, d2_q};
				quo_q <= '0;
				cnt_q <= 6'(DIV_STEPS - 1);
			end
			S_DIV: begin
				rem_q <= div_ge ? t_sub[32:0] : t[32:0];
				quo_q <= {quo_q[32:0], div_ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					x_q   <= {quo_q[32:0], div_ge};
					res_q <= '0;
					bit_q <= 34'd1 << 32;
				end
			end
			S_SQRT: begin
				x_q   <= sq_ge ? (x_q - sum[33:0]) : x_q;
				res_q <= res_nxt;
				bit_q <= bit_q >> 2;
				if (bit_q[0]) begin
					value_q <= rnd[18:17] != 2'b00 ? 16'hFFFF : rnd[16:1];
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

### hdl/hms_back.sv
// back: row stores, neighbour gather, slope launch and output register
// depends on hms_pkg and hms_slope
`default_nettype none

module hms_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         q_valid,
	input  wire hms_pkg::job_t                q_head,
	output logic                              pop,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [hms_pkg::SLOPE_W-1:0]       slope,
	output logic [hms_pkg::COL_W-1:0]         cell_col,
	output logic [hms_pkg::ROW_W-1:0]         cell_row,
	output logic                              frame_last
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RD1  = 5'b00010,
		S_GATH = 5'b00100,
		S_CALC = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t state_q;
	hms_pkg::job_t job_q;

	logic signed [hms_pkg::HEIGHT_W-1:0] upper_mem  [hms_pkg::MAX_WIDTH];
	logic signed [hms_pkg::HEIGHT_W-1:0] middle_mem [hms_pkg::MAX_WIDTH];
	logic signed [hms_pkg::HEIGHT_W-1:0] mid_rd_q;
	logic signed [hms_pkg::HEIGHT_W-1:0] up_rd_q;
	logic signed [hms_pkg::HEIGHT_W-1:0] centre_q;
	logic signed [hms_pkg::HEIGHT_W-1:0] upper_q;
	logic signed [hms_pkg::HEIGHT_W-1:0] left_q;

	logic                          rd_en;
	logic [hms_pkg::COL_W-1:0]     rd_addr;
	logic                          wr_en;
	logic [hms_pkg::SLOPE_W-1:0]   best;
	logic                          slope_start;
	logic                          slope_done;
	logic [hms_pkg::SLOPE_W-1:0]   slope_value;
	logic                          load;

	logic                          out_valid_q;
	logic [hms_pkg::SLOPE_W-1:0]   slope_q;
	logic [hms_pkg::COL_W-1:0]     col_q;
	logic [hms_pkg::ROW_W-1:0]     row_q;
	logic                          last_q;

	// largest positive drop so far
	function automatic logic [hms_pkg::SLOPE_W-1:0] take_drop(
		input logic [hms_pkg::SLOPE_W-1:0]       best_in,
		input logic signed [hms_pkg::HEIGHT_W-1:0] c,
		input logic signed [hms_pkg::HEIGHT_W-1:0] nb,
		input logic                              en
	);
		logic signed [hms_pkg::HEIGHT_W:0] d;
		d = {c[hms_pkg::HEIGHT_W-1], c} - {nb[hms_pkg::HEIGHT_W-1], nb};
		if (en && (d > 0) && (d[hms_pkg::SLOPE_W-1:0] > best_in)) begin
			return d[hms_pkg::SLOPE_W-1:0];
		end
		return best_in;
	endfunction

	assign pop     = (state_q == S_IDLE) && q_valid;
	assign rd_en   = pop || (state_q == S_RD1);
	assign rd_addr = (state_q == S_RD1) ? job_q.col + 1'b1 : q_head.col;
	assign wr_en   = (state_q == S_GATH) && job_q.write_en;

	// neighbour compare
	always_comb begin
		best = '0;
		best = take_drop(best, centre_q, job_q.height, job_q.use_below);
		best = take_drop(best, centre_q, upper_q, job_q.use_upper);
		best = take_drop(best, centre_q, left_q, job_q.use_left);
		best = take_drop(best, centre_q, mid_rd_q, job_q.use_right);
	end

	assign slope_start = (state_q == S_GATH) && job_q.emit;
	assign load        = (state_q == S_OUT) && (!out_valid_q || out_ready);

	hms_slope u_slope (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (slope_start),
		.drop   (best),
		.done   (slope_done),
		.value  (slope_value)
	);

	// row stores
	always_ff @(posedge clk) begin
		if (wr_en) begin
			upper_mem[job_q.col]  <= centre_q;
			middle_mem[job_q.col] <= job_q.height;
		end
		if (rd_en) begin
			mid_rd_q <= middle_mem[rd_addr];
			up_rd_q  <= upper_mem[rd_addr];
		end
	end

	// job sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (q_valid) state_q <= S_RD1;
				S_RD1:  state_q <= S_GATH;
				S_GATH: state_q <= job_q.emit ? S_CALC : S_IDLE;
				S_CALC: if (slope_done) state_q <= S_OUT;
				S_OUT:  if (load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// job payload and neighbour values
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= q_head;
		end
		if (state_q == S_RD1) begin
			centre_q <= mid_rd_q;
			upper_q  <= up_rd_q;
		end
		if (state_q == S_GATH) begin
			left_q <= centre_q;
		end
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slope_q <= slope_value;
			col_q   <= job_q.col;
			row_q   <= job_q.row;
			last_q  <= job_q.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign slope      = slope_q;
	assign cell_col   = col_q;
	assign cell_row   = row_q;
	assign frame_last = last_q;

	a_start_in_gather: assert property (@(posedge clk) disable iff (!arst_n)
		slope_start |-> state_q == S_GATH)
		else $error("slope unit started outside gather");

	a_done_moves_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CALC) && slope_done |=> state_q == S_OUT)
		else $error("slope result not taken");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == S_RD1)
		else $error("job popped without read");

	a_write_only_sample: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> job_q.use_below)
		else $error("row store written by a flush job");

endmodule

`default_nettype wire
